/* sv/slac_pkg.sv */
package slac_pkg;

    // Field widths fixed by the access and result formats
    localparam int TAG_W      = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Default geometry
    localparam int MAX_SET_BITS_DEF = 8;
    localparam int WAYS_DEF         = 8;

    // Access kinds
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_IFETCH = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Lookup outcome handed from the update logic to the controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } outcome_t;

endpackage

/* sv/slac_mem.sv */
module slac_mem
    import slac_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int DEPTH = 256,
    parameter int ROW_W = 8
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] rows_reg [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rows_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= rows_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/slac_update.sv */
module slac_update
    import slac_pkg::*;
#(
    parameter int WAYS  = 8,
    parameter int RW    = 3,
    parameter int ROW_W = 8
)
(
    input  logic [ROW_W-1:0] row,
    input  logic [TAG_W-1:0] tag,
    input  logic [3:0]       ways_cfg,
    output logic [ROW_W-1:0] new_row,
    output outcome_t         outcome
);

    localparam int RANK_OFS = WAYS;
    localparam int TAG_OFS  = WAYS + WAYS * RW;
    localparam logic [RW-1:0] RANK_MAX = RW'(WAYS - 1);

    logic [WAYS-1:0]  valid;
    logic [RW-1:0]    rank [WAYS];
    logic [TAG_W-1:0] line_tag [WAYS];
    logic [WAYS-1:0]  in_use;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  empty;
    logic [WAYS-1:0]  oldest;
    logic             found;
    logic             has_empty;
    logic [RW-1:0]    hit_way;
    logic [RW-1:0]    empty_way;
    logic [RW-1:0]    victim_way;
    logic [RW-1:0]    way;

    // Unpack the row and qualify each way
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            valid[i]    = row[i];
            rank[i]     = row[RANK_OFS + i * RW +: RW];
            line_tag[i] = row[TAG_OFS + i * TAG_W +: TAG_W];
            in_use[i]   = (i == 0) || (5'(i) < {1'b0, ways_cfg});
            match[i]    = in_use[i] && valid[i] && (line_tag[i] == tag);
            empty[i]    = in_use[i] && !valid[i];
        end
    end

    // Oldest way: strictly older than all lower ways, not younger than higher ones
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            oldest[i] = in_use[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (in_use[j] && (j < i) && !(rank[j] < rank[i]))
                begin
                    oldest[i] = 1'b0;
                end
                if (in_use[j] && (j > i) && (rank[j] > rank[i]))
                begin
                    oldest[i] = 1'b0;
                end
            end
        end
    end

    // Lowest-numbered way of each kind
    always_comb
    begin
        hit_way    = '0;
        empty_way  = '0;
        victim_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = RW'(i);
            end
            if (empty[i])
            begin
                empty_way = RW'(i);
            end
            if (oldest[i])
            begin
                victim_way = RW'(i);
            end
        end
        found     = |match;
        has_empty = |empty;
    end

    // Target way and outcome
    always_comb
    begin
        if (found)
        begin
            way = hit_way;
        end
        else if (has_empty)
        begin
            way = empty_way;
        end
        else
        begin
            way = victim_way;
        end
        outcome.hit   = found;
        outcome.miss  = !found;
        outcome.evict = !found && !has_empty;
    end

    // New row: target youngest; younger valid ways (all on a miss) age by one
    always_comb
    begin
        new_row = row;
        for (int i = 0; i < WAYS; i++)
        begin
            if (RW'(i) == way)
            begin
                new_row[i]                               = 1'b1;
                new_row[RANK_OFS + i * RW +: RW]         = '0;
                new_row[TAG_OFS + i * TAG_W +: TAG_W]    = tag;
            end
            else if (in_use[i] && valid[i] && (rank[i] < RANK_MAX)
                     && (!found || (rank[i] < rank[hit_way])))
            begin
                new_row[RANK_OFS + i * RW +: RW] = rank[i] + RW'(1);
            end
        end
    end

endmodule

/* sv/set_assoc_lru_cache_model_top.sv */
// Set-associative cache model with LRU replacement. An access is taken on start while
// busy is low and its result, registered from the lookup state, appears on done for exactly one
// cycle; the receiver cannot stall it. Each access reads the set's row from the line memory,
// then compares the configured ways in parallel and writes the updated row back (instruction
// fetches leave the row unchanged); busy is high during the lookup, so no new start is taken
// before the access is through. After reset, busy stays high while the line memory is
// cleared one row per cycle; configuration writes are taken at any time.
module set_assoc_lru_cache_model_top
    import slac_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int WAYS         = WAYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            op,
    input  logic [TAG_W-1:0]      address,
    output logic                  done,
    output logic                  was_hit,
    output logic                  was_miss,
    output logic                  was_eviction,
    output logic                  second_hit,
    output logic [CNT_W-1:0]      total_hits,
    output logic [CNT_W-1:0]      total_misses,
    output logic [CNT_W-1:0]      total_evictions
);

    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (1 + RW + TAG_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [3:0]         set_bits_reg;
    logic [3:0]         ways_reg;
    logic [5:0]         block_bits_reg;
    op_t                op_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [IDX_W-1:0]   set_reg;
    logic [CNT_W-1:0]   hit_total_reg, hit_total_next;
    logic [CNT_W-1:0]   miss_total_reg, miss_total_next;
    logic [CNT_W-1:0]   evict_total_reg, evict_total_next;
    logic               done_reg;
    logic               hit_reg, miss_reg, evict_reg, second_reg;

    logic               accept;
    logic               clearing;
    logic               lookup;
    logic               counted;
    logic [TAG_W-1:0]   tag_now;
    logic [IDX_W-1:0]   set_now;
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   upd_row;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]   mem_wdata;
    logic [CNT_W-1:0]   hit_once;
    outcome_t           outcome;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= 4'd1;
            block_bits_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SET_BITS:   set_bits_reg   <= cfg_wdata[3:0];
                REG_WAYS:       ways_reg       <= cfg_wdata[3:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_wdata[5:0];
                default:        ;
            endcase
        end
    end

    // Controller next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        busy     = 1'b1;
        clearing = 1'b0;
        lookup   = 1'b0;
        case (state_reg)
            ST_CLEAR:  clearing = 1'b1;
            ST_IDLE:   busy     = 1'b0;
            ST_LOOKUP: lookup   = 1'b1;
            default:   busy     = 1'b1;
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
        end
    end

    // Tag and set index of the incoming access
    always_comb
    begin
        tag_now = address >> block_bits_reg;
        set_now = '0;
        for (int i = 0; i < MAX_SET_BITS; i++)
        begin
            set_now[i] = tag_now[i] && (4'(i) < set_bits_reg);
        end
    end

    // Access capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            tag_reg <= tag_now;
            set_reg <= set_now;
        end
    end

    // Line memory: read on accept, write back in the lookup cycle (not for instruction fetches) or clear
    assign counted   = lookup && (op_reg != OP_IFETCH);
    assign mem_we    = clearing || counted;
    assign mem_waddr = clearing ? clr_idx_reg : set_reg;
    assign mem_wdata = clearing ? '0 : upd_row;

    slac_mem #(
        .IDX_W (IDX_W),
        .DEPTH (DEPTH),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (set_now),
        .rdata (rd_row)
    );

    slac_update #(
        .WAYS  (WAYS),
        .RW    (RW),
        .ROW_W (ROW_W)
    ) u_update (
        .row      (rd_row),
        .tag      (tag_reg),
        .ways_cfg (ways_reg),
        .new_row  (upd_row),
        .outcome  (outcome)
    );

    // Saturating totals
    always_comb
    begin
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        evict_total_next = evict_total_reg;
        hit_once         = hit_total_reg;
        if (counted)
        begin
            if (outcome.hit && (hit_total_reg != CNT_MAX))
            begin
                hit_once = hit_total_reg + CNT_W'(1);
            end
            hit_total_next = hit_once;
            if ((op_reg == OP_MODIFY) && (hit_once != CNT_MAX))
            begin
                hit_total_next = hit_once + CNT_W'(1);
            end
            if (outcome.miss && (miss_total_reg != CNT_MAX))
            begin
                miss_total_next = miss_total_reg + CNT_W'(1);
            end
            if (outcome.evict && (evict_total_reg != CNT_MAX))
            begin
                evict_total_next = evict_total_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
            done_reg        <= lookup;
        end
    end

    // Result flags
    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            hit_reg    <= counted && outcome.hit;
            miss_reg   <= counted && outcome.miss;
            evict_reg  <= counted && outcome.evict;
            second_reg <= (op_reg == OP_MODIFY);
        end
    end

    assign done            = done_reg;
    assign was_hit         = hit_reg;
    assign was_miss        = miss_reg;
    assign was_eviction    = evict_reg;
    assign second_hit      = second_reg;
    assign total_hits      = hit_total_reg;
    assign total_misses    = miss_total_reg;
    assign total_evictions = evict_total_reg;

    // Checks
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_LOOKUP))
        else $error("result strobe without a lookup cycle");

    a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_reg && miss_reg))
        else $error("access reported as both hit and miss");

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && evict_reg) |-> miss_reg)
        else $error("eviction without a miss");

    a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (state_reg != ST_LOOKUP))
        else $error("access taken during clearing pass");

    a_hits_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> (hit_total_reg == $past(hit_total_reg)) || $past(lookup))
        else $error("hit total changed outside a lookup");

endmodule
